// ----- src/assert_macros.svh -----
// Assertion helper macros for the five-point stencil RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pfps_pkg.sv -----
// Types, widths and register indexes for the five-point stencil block.
// No dependencies; used by the channel interfaces and the top level.
package pfps_pkg;

	localparam int SIDE_W   = 9;
	localparam int SCALE_W  = 32;
	localparam int CFG_W    = 32;
	localparam int SAMPLE_W = 24;
	localparam int VALUE_W  = 43;
	localparam int INDEX_W  = 16;
	localparam int CNT_W    = 17;
	localparam int BIT_W    = $clog2(CNT_W);
	localparam int TOT_W    = 2 * SIDE_W;
	localparam int TPN_W    = TOT_W + 1;
	localparam int SUM_W    = SAMPLE_W + 3;
	localparam int PROD_W   = SUM_W + SCALE_W + 1;
	localparam int FRAC_W   = 16;
	localparam int SLOT_W   = SIDE_W + 2;

	typedef logic [0:0]                   cfg_idx_t;
	typedef logic [SIDE_W-1:0]            side_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [SLOT_W-1:0]            slot_t;
	typedef logic signed [SAMPLE_W-1:0]   sample_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [VALUE_W-1:0]    value_t;
	typedef logic [INDEX_W-1:0]           index_t;

	localparam cfg_idx_t REG_GRID_SIDE = 1'b0;
	localparam cfg_idx_t REG_SCALE     = 1'b1;

	typedef enum logic [5:0] {
		ST_RUN  = 6'b000001,
		ST_SIZE = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_LOAD = 6'b010000,
		ST_FILL = 6'b100000
	} pfps_state_t;

	// v mod d for v < 2d
	function automatic slot_t wrap_slot(slot_t v, slot_t d);
		return (v >= d) ? (v - d) : v;
	endfunction

endpackage

// ----- src/pfps_if.sv -----
// Valid/ready channel interfaces for the stencil: sample words in, result words out.
// Depends on pfps_pkg.
interface pfps_in_if;
	import pfps_pkg::*;
	logic    valid;
	logic    ready;
	logic    flush;
	sample_t sample;
	modport source (output valid, flush, sample, input ready);
	modport sink   (input valid, flush, sample, output ready);
endinterface

interface pfps_out_if;
	import pfps_pkg::*;
	logic   valid;
	logic   ready;
	value_t stencil_value;
	index_t grid_index;
	logic   last_of_grid;
	modport source (output valid, stencil_value, grid_index, last_of_grid, input ready);
	modport sink   (input valid, stencil_value, grid_index, last_of_grid, output ready);
endinterface

// ----- src/poisson_five_point_stencil.sv -----
// Five-point Laplacian stencil over a streamed n-by-n grid; top level.
// Depends on pfps_pkg, pfps_if.sv and assert_macros.svh.
//
// Takes one sample word per cycle in row-major order, unless realigning or stalled by
// the output, and returns the scaled stencil of point k when word k+n is taken, so
// results trail by one row; n drain words after the grid return the last row. The window
// is a 2*MAX_SIDE x 24 memory with one write and two registered reads per cycle; the
// centre and left neighbour come from a short tap register and the lower one from the
// incoming word. Writing grid_side starts a realignment (a bit-serial remainder of the
// word counter) during which no sample word is taken; scale writes take effect at once.
`include "assert_macros.svh"

module poisson_five_point_stencil #(
	parameter int MAX_SIDE = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  pfps_pkg::cfg_idx_t         cfg_idx,
	input  logic [pfps_pkg::CFG_W-1:0] cfg_data,
	pfps_in_if.sink                    samples,
	pfps_out_if.source                 results
);
	import pfps_pkg::*;

	localparam int DEPTH = 2 * MAX_SIDE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	pfps_state_t st_q;
	side_t       side_q, n_q;
	logic [SCALE_W-1:0] scale_q;
	logic [TOT_W-1:0]   tot_q;
	logic [TPN_W-1:0]   tpn_q, lastm_q;
	cnt_t        m_q;
	slot_t       wp_q, col_q, rem_q;
	logic        wrap_q;
	logic [BIT_W-1:0] bit_q;

	sample_t     mem [DEPTH];
	sample_t     rda_q, rdb_q, xk_q, xkm1_q;

	logic        v_s1, v_s2;
	sum_t        val_s1;
	index_t      idx_s1, idx_s2;
	logic        last_s1, last_s2;
	value_t      value_s2;

	slot_t       n_s, two_n;
	cnt_t        m_eff, m_nx;
	slot_t       wp_eff, col_eff, wp_nx, col_nx, wp_inc, col_inc;
	slot_t       ra, rb, rem_sh;
	logic        accept, step, produce, wr_en, finished, in_grid;
	logic        has_up, has_left, has_right, adv;
	sum_t        val, t_up, t_dn, t_lf, t_rt;
	logic signed [PROD_W-1:0] prod;
	side_t       n_clamp;

	assign n_s   = SLOT_W'(n_q);
	assign two_n = SLOT_W'({n_q, 1'b0});

	assign adv    = !v_s2 || results.ready;
	assign samples.ready = (st_q == ST_RUN) && (!v_s1 || adv);
	assign accept = samples.valid && samples.ready;

	assign m_eff   = wrap_q ? '0 : m_q;
	assign wp_eff  = wrap_q ? '0 : wp_q;
	assign col_eff = wrap_q ? '0 : col_q;

	assign in_grid   = TPN_W'(m_eff) < TPN_W'(tot_q);
	assign step      = accept && !(in_grid && samples.flush);
	assign produce   = step && (TPN_W'(m_eff) >= TPN_W'(n_q));
	assign wr_en     = step && in_grid;
	assign finished  = produce && (TPN_W'(m_eff) == lastm_q);
	assign has_up    = TPN_W'(m_eff) >= TPN_W'(two_n);
	assign has_left  = col_eff != '0;
	assign has_right = col_eff != (n_s - SLOT_W'(1));

	always_comb begin
		t_up = has_up    ? SUM_W'(rdb_q)          : '0;
		t_dn = in_grid   ? SUM_W'(samples.sample) : '0;
		t_lf = has_left  ? SUM_W'(xkm1_q)         : '0;
		t_rt = has_right ? SUM_W'(rda_q)          : '0;
		val  = (SUM_W'(xk_q) <<< 2) - t_up - t_dn - t_lf - t_rt;
	end

	assign wp_inc  = (wp_eff + SLOT_W'(1) == two_n) ? '0 : (wp_eff + SLOT_W'(1));
	assign col_inc = (col_eff + SLOT_W'(1) == n_s) ? '0 : (col_eff + SLOT_W'(1));

	always_comb begin
		if (step && finished) begin
			m_nx   = '0;
			wp_nx  = '0;
			col_nx = '0;
		end else if (step) begin
			m_nx   = m_eff + CNT_W'(1);
			wp_nx  = wp_inc;
			col_nx = col_inc;
		end else begin
			m_nx   = m_q;
			wp_nx  = wp_q;
			col_nx = col_q;
		end
	end

	// read slots: x[m-n+1] and x[m-2n] for the coming word, or x[m-n], x[m-n-1] on realign
	always_comb begin
		if (st_q == ST_LOAD) begin
			ra = wrap_slot(wp_q + n_s, two_n);
			rb = wrap_slot(wp_q + n_s - SLOT_W'(1), two_n);
		end else begin
			ra = wrap_slot(wp_nx + n_s + SLOT_W'(1), two_n);
			rb = wp_nx;
		end
	end

	assign rem_sh = {rem_q[SLOT_W-2:0], m_q[bit_q]};

	always_comb begin
		if (side_q == '0)
			n_clamp = SIDE_W'(1);
		else if (32'(side_q) > 32'(MAX_SIDE))
			n_clamp = SIDE_W'(MAX_SIDE);
		else
			n_clamp = side_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_RUN;
			side_q  <= SIDE_W'(1);
			scale_q <= SCALE_W'(65536);
			n_q     <= SIDE_W'(1);
			tot_q   <= TOT_W'(1);
			tpn_q   <= TPN_W'(2);
			lastm_q <= TPN_W'(1);
			m_q     <= '0;
			wp_q    <= '0;
			col_q   <= '0;
			wrap_q  <= 1'b0;
			rem_q   <= '0;
			bit_q   <= '0;
		end else begin
			case (st_q)
				ST_RUN: begin
					m_q    <= m_nx;
					wp_q   <= wp_nx;
					col_q  <= col_nx;
					wrap_q <= wrap_q && !step;
				end
				ST_SIZE: begin
					n_q  <= n_clamp;
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					tot_q <= TOT_W'(n_q) * TOT_W'(n_q);
					rem_q <= '0;
					bit_q <= BIT_W'(CNT_W - 1);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= wrap_slot(rem_sh, two_n);
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						wp_q <= wrap_slot(rem_sh, two_n);
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					col_q   <= wrap_slot(wp_q, n_s);
					tpn_q   <= TPN_W'(tot_q) + TPN_W'(n_q);
					lastm_q <= TPN_W'(tot_q) + TPN_W'(n_q) - TPN_W'(1);
					wrap_q  <= TPN_W'(m_q) >= (TPN_W'(tot_q) + TPN_W'(n_q));
					st_q    <= ST_FILL;
				end
				ST_FILL: begin
					st_q <= ST_RUN;
				end
				default: begin
					st_q <= ST_RUN;
				end
			endcase
			if (cfg_we) begin
				case (cfg_idx)
					REG_GRID_SIDE: begin
						side_q <= cfg_data[SIDE_W-1:0];
						st_q   <= ST_SIZE;
					end
					REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// row window, write-through on a same-slot read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(wp_eff)] <= samples.sample;
		rda_q <= (wr_en && ra == wp_eff) ? samples.sample : mem[AW'(ra)];
		rdb_q <= (wr_en && rb == wp_eff) ? samples.sample : mem[AW'(rb)];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FILL) begin
			xk_q   <= rda_q;
			xkm1_q <= rdb_q;
		end else if (st_q == ST_RUN && step) begin
			xk_q   <= (n_q == SIDE_W'(1)) ? samples.sample : rda_q;
			xkm1_q <= xk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv)
				v_s2 <= v_s1;
			if (!v_s1 || adv)
				v_s1 <= produce;
		end
	end

	assign prod = PROD_W'(val_s1) * PROD_W'($signed({1'b0, scale_q}));

	always_ff @(posedge clk) begin
		if (produce) begin
			val_s1  <= val;
			idx_s1  <= INDEX_W'(m_eff - CNT_W'(n_q));
			last_s1 <= finished;
		end
		if (adv && v_s1) begin
			value_s2 <= prod[FRAC_W +: VALUE_W];
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
		end
	end

	assign results.valid         = v_s2;
	assign results.stencil_value = value_s2;
	assign results.grid_index    = idx_s2;
	assign results.last_of_grid  = last_s2;

	`ASSERT_IMPLIES(a_busy_blocks_input, clk, arst_n, st_q != ST_RUN, !samples.ready, "sample taken during realign")
	`ASSERT_IMPLIES(a_pointer_range, clk, arst_n, st_q == ST_RUN && !wrap_q, wp_q < two_n && col_q < n_s && wrap_slot(wp_q, n_s) == col_q, "window pointer out of step")
	`ASSERT_NEXT(a_grid_restart, clk, arst_n, finished, m_q == '0 && wp_q == '0 && col_q == '0, "counters not cleared after last point")
	`ASSERT_NEXT(a_side_write_realigns, clk, arst_n, cfg_we && cfg_idx == REG_GRID_SIDE, st_q == ST_SIZE, "grid_side write did not start realign")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for poisson_five_point_stencil: directed grids, then random grids
// under three sender/receiver idle mixes, each result checked against a built-in predictor.
// Depends on pfps_pkg, pfps_if.sv and the stencil RTL.
`timescale 1ns / 1ps

module testbench;
	import pfps_pkg::*;

	localparam int MAX_SIDE = 256;
	localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
	localparam sample_t SAMPLE_MIN = 24'sh800000;
	localparam int SETTLE = 8;

	typedef struct {
		value_t value;
		index_t index;
		logic   last;
	} stencil_point_t;

	class grid_stencil;
		logic [SIDE_W-1:0]  side_reg;
		logic [SCALE_W-1:0] scale_reg;
		sample_t            window [2*MAX_SIDE];
		bit                 written[2*MAX_SIDE];
		int unsigned        taken;
		int unsigned        errors;
		stencil_point_t     pending[$];

		function new();
			side_reg  = 1;
			scale_reg = 32'h0001_0000;
			taken     = 0;
			errors    = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			if (idx == REG_GRID_SIDE)
				side_reg = data[SIDE_W-1:0];
			else
				scale_reg = data[SCALE_W-1:0];
		endfunction

		function int unsigned eff_side(int unsigned raw);
			if (raw == 0)
				return 1;
			if (raw > MAX_SIDE)
				return MAX_SIDE;
			return raw;
		endfunction

		function longint rd(int unsigned p, int unsigned n);
			return longint'(window[p % (2*n)]);
		endfunction

		// a side change must never make the window read a slot not yet written
		function bit side_change_safe(int unsigned raw);
			int unsigned n;
			int unsigned s;
			n = eff_side(raw);
			if (taken == 0 || taken >= n*n + n || n == eff_side(side_reg))
				return 1;
			for (s = 0; s < 2*n; s++)
				if (!written[s])
					return 0;
			return 1;
		endfunction

		function void take_word(logic flush, sample_t smp);
			int unsigned n, total, m, k, i, j;
			longint val, sc, prod;
			sample_t s;
			stencil_point_t p;
			bit finished;
			n     = eff_side(side_reg);
			total = n * n;
			if (taken >= total + n)
				taken = 0;
			m = taken;
			if (m < total && flush)
				return;
			s = (m < total) ? smp : '0;
			finished = 0;
			if (m >= n) begin
				k = m - n;
				i = k / n;
				j = k % n;
				val = 4 * rd(k, n);
				if (i > 0)
					val -= rd(k - n, n);
				if (i < n - 1)
					val -= s;
				if (j > 0)
					val -= rd(k - 1, n);
				if (j < n - 1)
					val -= rd(k + 1, n);
				sc = scale_reg;
				prod = val * sc;
				p.value = prod >>> 16;
				p.index = index_t'(k);
				p.last  = (k == total - 1);
				pending.push_back(p);
				finished = (k == total - 1);
			end
			if (m < total) begin
				window[m % (2*n)]  = s;
				written[m % (2*n)] = 1;
			end
			taken = (m + 1) & 32'h1FFFF;
			if (finished)
				taken = 0;
		endfunction

		function void check_result(value_t v, index_t idx, logic last);
			stencil_point_t p;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual value %0d index %0d last %0b",
					$time, v, idx, last);
				errors++;
				return;
			end
			p = pending.pop_front();
			if (v !== p.value) begin
				$display("%0t: stencil_value: expected %0d, actual %0d (index %0d)",
					$time, p.value, v, p.index);
				errors++;
			end
			if (idx !== p.index) begin
				$display("%0t: grid_index: expected %0d, actual %0d", $time, p.index, idx);
				errors++;
			end
			if (last !== p.last) begin
				$display("%0t: last_of_grid: expected %0b, actual %0b (index %0d)",
					$time, p.last, last, p.index);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_idx;
	logic [CFG_W-1:0]   cfg_data;

	pfps_in_if  in_ch();
	pfps_out_if out_ch();

	grid_stencil sb = new();

	int unsigned src_idle_pct  = 37;
	int unsigned sink_idle_pct = 88;
	int          hold_cycles   = 0;

	poisson_five_point_stencil #(.MAX_SIDE(MAX_SIDE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.samples  (in_ch),
		.results  (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls plus a counted hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.stencil_value, out_ch.grid_index, out_ch.last_of_grid);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic sample_t pick_sample();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return SAMPLE_MAX;
		if (r < 20)
			return SAMPLE_MIN;
		return sample_t'($urandom_range(24'hFFFFFF, 0));
	endfunction

	function automatic int unsigned pick_side();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 70)
			return $urandom_range(6, 1);
		if (r < 95)
			return $urandom_range(14, 7);
		return $urandom_range(20, 15);
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 30)
			return 32'h0001_0000;
		return $urandom();
	endfunction

	task automatic send_word(logic flush, sample_t smp);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.flush  <= flush;
		in_ch.sample <= smp;
		do @(posedge clk); while (!in_ch.ready);
		sb.take_word(flush, smp);
	endtask

	// drop valid, let every pending word arrive, then allow for in-flight no-result words
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_grid_regs(logic [SIDE_W-1:0] side, logic [SCALE_W-1:0] scl);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SCALE;
		cfg_data <= scl;
		@(posedge clk);
		sb.set_reg(REG_SCALE, scl);
		cfg_idx  <= REG_GRID_SIDE;
		cfg_data <= CFG_W'(side);
		@(posedge clk);
		sb.set_reg(REG_GRID_SIDE, CFG_W'(side));
		cfg_we <= 1'b0;
	endtask

	// samples with occasional in-grid flush noise, then drain words; stops early when asked
	task automatic feed_grid(int unsigned n, int unsigned stop_at);
		int unsigned p;
		for (p = 0; p < n*n + n && p < stop_at; p++) begin
			if (p < n*n) begin
				if ($urandom_range(99) < 4)
					send_word(1'b1, pick_sample());
				send_word(1'b0, pick_sample());
			end else if ($urandom_range(99) < 20) begin
				send_word(1'b0, pick_sample());
			end else begin
				send_word(1'b1, pick_sample());
			end
		end
	endtask

	initial begin
		int unsigned src_pct [3];
		int unsigned sink_pct[3];
		int unsigned p, n, side, stop, words;
		logic [SCALE_W-1:0] scl;
		int ph;

		src_pct  = '{37, 88, 0};
		sink_pct = '{88, 37, 0};
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_idx      <= REG_GRID_SIDE;
		cfg_data     <= '0;
		in_ch.valid  <= 1'b0;
		in_ch.flush  <= 1'b0;
		in_ch.sample <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: 1x1 grid, flush before the first sample, then a sample while draining
		send_word(1'b1, pick_sample());
		send_word(1'b0, SAMPLE_MAX);
		send_word(1'b0, pick_sample());

		// 3x3 checkerboard of extremes at the largest scale
		quiesce();
		load_grid_regs(3, '1);
		for (p = 0; p < 9; p++)
			send_word(1'b0, (p % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		for (p = 0; p < 3; p++)
			send_word(1'b1, pick_sample());

		// side shrinks mid-grid, counters kept
		for (p = 0; p < 4; p++)
			send_word(1'b0, pick_sample());
		quiesce();
		load_grid_regs(2, 32'h0001_0000);
		send_word(1'b1, pick_sample());
		send_word(1'b1, pick_sample());

		// oversized side, then side 0 mid-grid forces a counter restart
		quiesce();
		load_grid_regs(300, 32'h0001_0000);
		for (p = 0; p < 3; p++)
			send_word(1'b0, pick_sample());
		quiesce();
		load_grid_regs(0, '0);
		send_word(1'b0, SAMPLE_MIN);
		send_word(1'b1, pick_sample());

		for (ph = 0; ph < 3; ph++) begin
			src_idle_pct  = src_pct[ph];
			sink_idle_pct = sink_pct[ph];
			if (ph == 2) begin
				// receiver holds off while the sender keeps pushing
				quiesce();
				load_grid_regs(10, 32'h0001_0000);
				hold_cycles = 300;
				feed_grid(10, 110);
				quiesce();
				load_grid_regs(256, pick_scale());
				feed_grid(256, 256*256 + 256);
			end
			words = 0;
			while (words < 400) begin
				side = pick_side();
				scl  = pick_scale();
				quiesce();
				if (!sb.side_change_safe(side))
					side = sb.side_reg;
				load_grid_regs(side, scl);
				n = sb.eff_side(side);
				stop = ($urandom_range(99) < 10) ? $urandom_range(n*n + n, 1) : n*n + n;
				feed_grid(n, stop);
				words += stop;
			end
		end

		quiesce();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/pfps_pkg.sv
src/pfps_if.sv
src/poisson_five_point_stencil.sv
tb/sv/testbench.sv
